// File: rtl/core/pip_pkg.sv
// Package for the point-in-polygon test core: opcodes, register indexes,
// sequencer states and default sizes. Depends on nothing.
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 128;
  localparam int COORD_WIDTH_DEF  = 32;
  localparam int VCOUNT_W         = 8;
  localparam int VINDEX_W         = 7;

  typedef enum logic {
    OP_WRITE_VERTEX,
    OP_TEST_POINT
  } opcode_t;

  typedef enum logic [0:0] {
    REG_VERTEX_COUNT,
    REG_KEEP_INSIDE
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH0,
    ST_FETCH1,
    ST_FETCH2,
    ST_DIFF,
    ST_MUL1,
    ST_MUL2,
    ST_FINISH
  } pip_state_t;

endpackage

// File: rtl/core/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/point_in_polygon_test_core.sv
// Point-in-polygon test core (crossing-number rule) with its vertex RAM.
// Depends on pip_pkg and pip_ram.
//
// A start with opcode 0 writes one vertex and gives no result. A start with
// opcode 1 tests a point against the polygon of vertex_count vertices and
// gives one result, strobed by out_valid for one cycle, which the receiver
// must take as it comes. With n > 0 vertices in use the core is busy through
// ST_FETCH0..ST_FETCH2, ST_DIFF, ST_MUL1 and ST_MUL2 per edge, then ST_FINISH,
// and the result appears in the cycle after that; with n = 0 it follows in
// the next cycle. The test time is set by the single shared multiplier, which
// forms the two cross products of each edge in turn after an operand step,
// and by the one read port of the vertex RAM, which feeds one vertex per edge.
// The vertex RAM needs no clearing after reset.
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  pip_pkg::opcode_t                   in_opcode,
  input  logic [pip_pkg::VINDEX_W-1:0]       in_vertex_index,
  input  logic signed [COORD_WIDTH-1:0]      in_coord_x,
  input  logic signed [COORD_WIDTH-1:0]      in_coord_y,
  output logic                               out_valid,
  output logic                               out_inside_res,
  output logic                               out_selected,
  input  logic                               cfg_we,
  input  pip_pkg::cfg_index_t                cfg_index,
  input  logic [pip_pkg::VCOUNT_W-1:0]       cfg_wdata
);

  import pip_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  pip_state_t state_r, state_nxt;
  logic [NW-1:0] n_r, n_cap;
  logic [NW-1:0] k_r, k_nxt;
  logic [NW:0]   kp2;
  logic          wrap;
  logic          parity_r, parity_nxt;
  logic          toggle;
  logic          accept;
  logic          out_valid_r, out_valid_nxt;
  logic          out_inside_r, out_inside_nxt;
  logic          out_sel_r;

  logic [VCOUNT_W-1:0] vcount_r;
  logic                keep_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [2*CW-1:0]     ram_rdata;
  logic signed [CW-1:0] rd_x, rd_y;

  logic signed [CW-1:0] px_r, py_r;
  logic signed [CW-1:0] v0x_r, v0y_r;
  logic signed [CW-1:0] prevx_r, prevy_r;
  logic signed [CW-1:0] curx_r, cury_r;
  logic signed [DW-1:0] dxp_r, dy_r, dyp_r, dx_r;
  logic                 en_r, up_r;
  logic signed [PW-1:0] prod1_r, prod2_r;
  logic                 cmp_en_r, cmp_up_r;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign n_cap = (32'(vcount_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_r);
  assign kp2   = {1'b0, k_r} + (NW + 1)'(2);
  assign wrap  = (kp2 == {1'b0, n_r});

  assign ram_we    = accept && (in_opcode == OP_WRITE_VERTEX) &&
                     (32'(in_vertex_index) < MAX_VERTICES);
  assign ram_waddr = AW'(in_vertex_index);
  assign rd_x      = ram_rdata[2*CW-1:CW];
  assign rd_y      = ram_rdata[CW-1:0];

  pip_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({in_coord_x, in_coord_y}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign mul_a = (state_r == ST_MUL1) ? dxp_r : dyp_r;
  assign mul_b = (state_r == ST_MUL1) ? dy_r : dx_r;
  assign mul_p = mul_a * mul_b;

  assign toggle = cmp_en_r && (cmp_up_r ? (prod1_r < prod2_r) : (prod1_r > prod2_r));

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    parity_nxt     = parity_r;
    out_valid_nxt  = 1'b0;
    out_inside_nxt = out_inside_r;
    ram_raddr      = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_opcode == OP_TEST_POINT)) begin
          k_nxt      = '0;
          parity_nxt = 1'b0;
          if (n_cap == '0) begin
            out_valid_nxt  = 1'b1;
            out_inside_nxt = 1'b0;
          end else begin
            state_nxt = ST_FETCH0;
          end
        end
      end
      ST_FETCH0: begin
        state_nxt = ST_FETCH1;
      end
      ST_FETCH1: begin
        ram_raddr = AW'(1);
        state_nxt = ST_FETCH2;
      end
      ST_FETCH2: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        ram_raddr  = AW'(kp2);
        parity_nxt = parity_r ^ toggle;
        state_nxt  = ST_MUL1;
      end
      ST_MUL1: begin
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        k_nxt = k_r + NW'(1);
        if (k_r == n_r - NW'(1)) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_DIFF;
        end
      end
      ST_FINISH: begin
        parity_nxt     = parity_r ^ toggle;
        out_valid_nxt  = 1'b1;
        out_inside_nxt = parity_r ^ toggle;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
      cmp_en_r    <= 1'b0;
      vcount_r    <= '0;
      keep_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_VERTEX_COUNT: vcount_r <= cfg_wdata;
          REG_KEEP_INSIDE:  keep_r   <= cfg_wdata[0];
          default:          vcount_r <= vcount_r;
        endcase
      end
      if (state_r == ST_MUL2) begin
        cmp_en_r <= en_r;
      end else if ((state_r == ST_IDLE) || (state_r == ST_FINISH)) begin
        cmp_en_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_inside_r <= out_inside_nxt;
    out_sel_r    <= out_inside_nxt ^ ~keep_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          px_r <= in_coord_x;
          py_r <= in_coord_y;
          n_r  <= n_cap;
        end
      end
      ST_FETCH1: begin
        v0x_r  <= rd_x;
        v0y_r  <= rd_y;
        curx_r <= rd_x;
        cury_r <= rd_y;
      end
      ST_FETCH2: begin
        prevx_r <= curx_r;
        prevy_r <= cury_r;
        if (n_r != NW'(1)) begin
          curx_r <= rd_x;
          cury_r <= rd_y;
        end
      end
      ST_DIFF: begin
        dxp_r <= DW'(px_r) - DW'(prevx_r);
        dy_r  <= DW'(cury_r) - DW'(prevy_r);
        dyp_r <= DW'(py_r) - DW'(prevy_r);
        dx_r  <= DW'(curx_r) - DW'(prevx_r);
        en_r  <= (cury_r != prevy_r) && ((py_r < prevy_r) == (py_r > cury_r));
        up_r  <= (cury_r > prevy_r);
      end
      ST_MUL1: begin
        prod1_r <= mul_p;
        prevx_r <= curx_r;
        prevy_r <= cury_r;
        curx_r  <= wrap ? v0x_r : rd_x;
        cury_r  <= wrap ? v0y_r : rd_y;
      end
      ST_MUL2: begin
        prod2_r  <= mul_p;
        cmp_up_r <= up_r;
      end
      default: begin
        px_r <= px_r;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_selected   = out_sel_r;

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == OP_WRITE_VERTEX) |=> !out_valid)
    else $error("vertex write produced a result");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL2) |-> (k_r < n_r))
    else $error("edge counter ran past the vertex count");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r == ST_FINISH) ||
                   $past(accept && (in_opcode == OP_TEST_POINT))))
    else $error("result strobe without a finished test");

  a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_opcode == OP_TEST_POINT) && (n_cap != '0) |=> busy)
    else $error("test transfer did not start the edge walk");

endmodule
